// ----- rtl/pbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared widths, payload structs and divider handshake types for the
// proportional budget split block.
// ----------------------------------------------------------------------------
package pbs_pkg;

  // set size and field widths
  localparam int unsigned MAX_SEG   = 16;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned BUDGET_W  = 20;
  localparam int unsigned TOTAL_W   = 20;
  localparam int unsigned SEG_IDX_W = 4;

  // derived widths
  localparam int unsigned IDX_W    = (MAX_SEG > 1) ? $clog2(MAX_SEG) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_SEG + 1);
  localparam int unsigned PROD_W   = BUDGET_W + SIZE_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W + 1);

  // input beat
  typedef struct packed {
    logic [SIZE_W-1:0] segment_size;
    logic              last_segment;
  } seg_in_t;

  // result beat
  typedef struct packed {
    logic [SEG_IDX_W-1:0] segment_index;
    logic [BUDGET_W-1:0]  allocation;
    logic                 last_result;
  } res_t;

  // divider request
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TOTAL_W-1:0] divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic                done;
    logic [BUDGET_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/pbs_divider.sv -----
// ----------------------------------------------------------------------------
// pbs_divider
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// known to fit the budget width, so only its low bits are returned.
// ----------------------------------------------------------------------------
module pbs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pbs_pkg::div_req_t  req_i,
  output pbs_pkg::div_rsp_t  rsp_o
);

  logic [pbs_pkg::PROD_W-1:0]    dvd_q, dvd_d;
  logic [pbs_pkg::TOTAL_W-1:0]   rem_q, rem_d;
  logic [pbs_pkg::TOTAL_W-1:0]   dsr_q, dsr_d;
  logic [pbs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [pbs_pkg::TOTAL_W:0]     trial;
  logic                          qbit;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, dvd_q[pbs_pkg::PROD_W-1]};
    qbit   = (trial >= {1'b0, dsr_q});
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      rem_d = '0;
      cnt_d = pbs_pkg::DIV_CNT_W'(pbs_pkg::PROD_W);
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[pbs_pkg::PROD_W-2:0], qbit};
      rem_d = qbit ? pbs_pkg::TOTAL_W'(trial - {1'b0, dsr_q})
                   : pbs_pkg::TOTAL_W'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pbs_pkg::DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q[pbs_pkg::BUDGET_W-1:0];

endmodule

// ----- rtl/proportional_budget_split.sv -----
// ----------------------------------------------------------------------------
// proportional_budget_split
// Splits a configured budget across a set of segments in proportion to
// their sizes, with a one-unit floor and largest-first rounding.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid_i/cfg_ready_o/cfg_data_i write the budget; ready is high while
//   the block waits for segment beats.
//   A segment beat is taken at an edge with start high and busy low, one per
//   cycle. Sizes go into a 16-entry size RAM and are summed; beats past the
//   sixteenth are dropped, but a last mark on them still closes the set.
//   After the last beat busy rises and the block computes, then emits one
//   result beat per segment on out_strobe_o, in index order, each for one
//   cycle; the receiver cannot stall. busy falls as the final beat is shown.
//   Stepping: the share pass runs when units remain to share and the total is
//   nonzero, one serial divide per segment; the output pass reads each
//   segment and, when rounding units remain, ranks it by scanning every size
//   through the single read port of the size RAM.
//   Reset clears the budget, the segment count and the running total; the
//   size RAM is not cleared.
// ----------------------------------------------------------------------------
module proportional_budget_split (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbs_pkg::BUDGET_W-1:0]  cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  pbs_pkg::seg_in_t              seg_i,
  output logic                          out_strobe_o,
  output pbs_pkg::res_t                 res_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_SHR, S_MUL, S_DIVS, S_DIVW,
    S_ORD, S_OCAP, S_RRD, S_RCMP, S_EMIT
  } state_e;

  state_e                       state_q, state_d;
  logic [pbs_pkg::CNT_W-1:0]    count_q, count_d;
  logic [pbs_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic [pbs_pkg::BUDGET_W-1:0] budget_q, budget_d;
  logic [pbs_pkg::BUDGET_W-1:0] remaining_q, remaining_d;
  logic [pbs_pkg::BUDGET_W-1:0] dist_q, dist_d;
  logic [pbs_pkg::BUDGET_W-1:0] leftover_q, leftover_d;
  logic                         div_en_q, div_en_d;
  logic [pbs_pkg::IDX_W-1:0]    i_q, i_d;
  logic [pbs_pkg::IDX_W-1:0]    j_q, j_d;
  logic [pbs_pkg::CNT_W-1:0]    rank_q, rank_d;
  logic [pbs_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [pbs_pkg::SIZE_W-1:0]   cur_size_q, cur_size_d;
  logic [pbs_pkg::BUDGET_W-1:0] cur_share_q, cur_share_d;
  logic                         res_valid_q, res_valid_d;
  pbs_pkg::res_t                res_q, res_d;

  logic [pbs_pkg::SIZE_W-1:0]   size_mem [pbs_pkg::MAX_SEG];
  logic [pbs_pkg::BUDGET_W-1:0] share_mem [pbs_pkg::MAX_SEG];
  logic [pbs_pkg::SIZE_W-1:0]   size_rd_q;
  logic [pbs_pkg::BUDGET_W-1:0] share_rd_q;
  logic [pbs_pkg::IDX_W-1:0]    size_raddr;

  logic                         in_accept;
  logic                         store_en;
  logic [pbs_pkg::BUDGET_W-1:0] count_ext;
  logic [pbs_pkg::BUDGET_W-1:0] floor_units;
  logic [pbs_pkg::BUDGET_W-1:0] rem_calc;
  logic [pbs_pkg::BUDGET_W-1:0] dist_next;
  logic                         i_last;
  logic                         j_last;
  logic                         floor_bit;
  logic                         bump_bit;
  pbs_pkg::div_req_t            div_req;
  pbs_pkg::div_rsp_t            div_rsp;

  // handshakes
  assign busy        = (state_q != S_LOAD);
  assign cfg_ready_o = (state_q == S_LOAD);
  assign in_accept   = start && !busy;
  assign store_en    = in_accept && (count_q < pbs_pkg::CNT_W'(pbs_pkg::MAX_SEG));

  // loop bounds and per-segment terms
  assign count_ext   = pbs_pkg::BUDGET_W'(count_q);
  assign floor_units = (budget_q < count_ext) ? budget_q : count_ext;
  assign rem_calc    = budget_q - floor_units;
  assign dist_next   = dist_q + div_rsp.quotient;
  assign i_last      = (pbs_pkg::CNT_W'(i_q) + 1'b1) == count_q;
  assign j_last      = (pbs_pkg::CNT_W'(j_q) + 1'b1) == count_q;
  assign floor_bit   = pbs_pkg::BUDGET_W'(i_q) < budget_q;
  assign bump_bit    = pbs_pkg::BUDGET_W'(rank_q) < leftover_q;

  // ram read address
  assign size_raddr = (state_q == S_RRD) ? j_q : i_q;

  // divider hookup
  assign div_req.start    = (state_q == S_DIVS);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = total_q;

  pbs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    budget_d    = budget_q;
    remaining_d = remaining_q;
    dist_d      = dist_q;
    leftover_d  = leftover_q;
    div_en_d    = div_en_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    prod_d      = prod_q;
    cur_size_d  = cur_size_q;
    cur_share_d = cur_share_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (cfg_valid_i && cfg_ready_o) begin
      budget_d = cfg_data_i;
    end

    unique case (state_q)
      S_LOAD: begin
        if (store_en) begin
          count_d = count_q + 1'b1;
          total_d = total_q + pbs_pkg::TOTAL_W'(seg_i.segment_size);
        end
        if (in_accept && seg_i.last_segment) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        remaining_d = rem_calc;
        div_en_d    = (rem_calc != '0) && (total_q != '0);
        dist_d      = '0;
        leftover_d  = '0;
        i_d         = '0;
        state_d     = ((rem_calc != '0) && (total_q != '0)) ? S_SHR : S_ORD;
      end
      S_SHR: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = pbs_pkg::PROD_W'(remaining_q) * pbs_pkg::PROD_W'(size_rd_q);
        state_d = S_DIVS;
      end
      S_DIVS: begin
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          dist_d = dist_next;
          if (i_last) begin
            leftover_d = remaining_q - dist_next;
            i_d        = '0;
            state_d    = S_ORD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_SHR;
          end
        end
      end
      S_ORD: begin
        state_d = S_OCAP;
      end
      S_OCAP: begin
        cur_size_d  = size_rd_q;
        cur_share_d = div_en_q ? share_rd_q : '0;
        j_d         = '0;
        rank_d      = '0;
        state_d     = (leftover_q != '0) ? S_RRD : S_EMIT;
      end
      S_RRD: begin
        state_d = S_RCMP;
      end
      S_RCMP: begin
        // segment j ranks ahead when larger, or equal with lower index
        if ((size_rd_q > cur_size_q) || ((size_rd_q == cur_size_q) && (j_q < i_q))) begin
          rank_d = rank_q + 1'b1;
        end
        if (j_last) begin
          state_d = S_EMIT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RRD;
        end
      end
      S_EMIT: begin
        res_valid_d         = 1'b1;
        res_d.segment_index = pbs_pkg::SEG_IDX_W'(i_q);
        res_d.allocation    = cur_share_q + pbs_pkg::BUDGET_W'(floor_bit)
                              + pbs_pkg::BUDGET_W'(bump_bit);
        res_d.last_result   = i_last;
        if (i_last) begin
          count_d = '0;
          total_d = '0;
          i_d     = '0;
          state_d = S_LOAD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_ORD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      total_q     <= '0;
      budget_q    <= '0;
      div_en_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      budget_q    <= budget_d;
      div_en_q    <= div_en_d;
      i_q         <= i_d;
      j_q         <= j_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    remaining_q <= remaining_d;
    dist_q      <= dist_d;
    leftover_q  <= leftover_d;
    rank_q      <= rank_d;
    prod_q      <= prod_d;
    cur_size_q  <= cur_size_d;
    cur_share_q <= cur_share_d;
    res_q       <= res_d;
  end

  // size ram, one write and one read port
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      size_mem[count_q[pbs_pkg::IDX_W-1:0]] <= seg_i.segment_size;
    end
    size_rd_q <= size_mem[size_raddr];
  end

  // share ram
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DIVW) && div_rsp.done) begin
      share_mem[i_q] <= div_rsp.quotient;
    end
    share_rd_q <= share_mem[i_q];
  end

  assign out_strobe_o = res_valid_q;
  assign res_o        = res_q;

  // checks
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == S_EMIT))
    else $error("result beat without emit step");

  a_last_closes_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last_result) |-> (state_q == S_LOAD) && (count_q == '0))
    else $error("final result beat did not return to load");

  a_leftover_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (leftover_q < count_ext))
    else $error("rounding leftover not below segment count");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVW))
    else $error("divider finished outside share wait");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pbs_pkg::CNT_W'(pbs_pkg::MAX_SEG))
    else $error("segment count beyond capacity");

endmodule
